// File: rtl/core/sphere_region_enter_leave_top_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SPHERE_REGION_ENTER_LEAVE_TOP_ASSERT_SVH
`define SPHERE_REGION_ENTER_LEAVE_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define SREL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked outside reset.
`define SREL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked during reset too.
`define SREL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/srel_pkg.sv
package srel_pkg;

  localparam int ID_W       = 64;
  localparam int POS_W      = 24;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * DIFF_W - 1;
  localparam int SUM_W      = SQ_W + 1;
  localparam int RAD_W      = 52;
  localparam int HH_W       = 23;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int IN_DATA_W  = ID_W + 3 * POS_W;
  localparam int OUT_USER_W = 2;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RADIUS_SQ   = 3'd3,
    REG_HALF_HEIGHT = 3'd4
  } cfg_reg_t;

  localparam logic EVENT_ENTER = 1'b0;
  localparam logic EVENT_LEAVE = 1'b1;

  typedef struct packed {
    logic            commit;
    logic            in_region;
    logic [ID_W-1:0] unit_id;
  } srel_tbl_req_t;

  typedef struct packed {
    logic hit;
    logic full;
  } srel_tbl_rsp_t;

endpackage

// File: rtl/core/sphere_region_enter_leave_top.sv
// Enter/leave detector for one spherical region with a vertical slab limit.
// Each input word reports a unit identifier and its Q18.6 position; a word
// comes out only when the unit crosses the region boundary: an enter
// (tuser bit 0 low, bit 1 set when the membership table was full and the
// unit was not recorded) or a leave. The block takes one report per clock
// cycle unless back-pressure from out_tready holds it; a result passes
// three registers: an input register, a stage that forms the three squared
// distances, and a stage that sums them, compares against the radius,
// looks up all MEMBER_SLOTS table entries at once and updates at most one,
// which also sets the cycle time. Reset empties the table at once. Registers
// sit on the configuration port at byte addresses 0x00, 0x08, 0x10, 0x18,
// 0x20; the user must write them only while idle; the block does not enforce it.
module sphere_region_enter_leave_top
  import srel_pkg::*;
#(
  parameter int MEMBER_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: unit_id[63:0], pos_x[87:64], pos_y[111:88], pos_z[135:112]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: event_unit[63:0]
  output logic [ID_W-1:0]       out_tdata,
  // out_tuser: event_kind[0], overflow[1]
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers.
  logic signed [POS_W-1:0] center_x_r;
  logic signed [POS_W-1:0] center_y_r;
  logic signed [POS_W-1:0] center_z_r;
  logic [RAD_W-1:0]        radius_sq_r;
  logic [HH_W-1:0]         half_height_r;
  logic                    cfg_wr;
  cfg_reg_t                cfg_sel;

  // Pipeline.
  logic                    s1_v_r;
  logic [ID_W-1:0]         s1_id_r;
  logic signed [POS_W-1:0] s1_px_r;
  logic signed [POS_W-1:0] s1_py_r;
  logic signed [POS_W-1:0] s1_pz_r;

  logic                    s2_v_r;
  logic [ID_W-1:0]         s2_id_r;
  logic [SQ_W-1:0]         s2_sqx_r;
  logic [SQ_W-1:0]         s2_sqy_r;
  logic [SQ_W-1:0]         s2_sqz_r;
  logic                    s2_zin_r;

  logic                    out_v_r;
  logic                    out_kind_r;
  logic                    out_ovf_r;
  logic [ID_W-1:0]         out_unit_r;

  logic                    adv3;
  logic                    adv2;
  logic                    in_acc;

  logic signed [DIFF_W-1:0]   dx;
  logic signed [DIFF_W-1:0]   dy;
  logic signed [DIFF_W-1:0]   dz;
  logic signed [2*DIFF_W-1:0] px2;
  logic signed [2*DIFF_W-1:0] py2;
  logic signed [2*DIFF_W-1:0] pz2;
  logic signed [DIFF_W:0]     dz_w;
  logic signed [DIFF_W:0]     hh_w;
  logic                       zin;

  logic [SUM_W-1:0]        dist_sq;
  logic                    in_region;
  logic                    commit;
  logic                    has_result;
  logic                    res_kind;
  logic                    res_ovf;
  srel_tbl_req_t           tbl_req;
  srel_tbl_rsp_t           tbl_rsp;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_z_r    <= '0;
      radius_sq_r   <= '0;
      half_height_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_CENTER_X:    center_x_r    <= cfg_pwdata[POS_W-1:0];
        REG_CENTER_Y:    center_y_r    <= cfg_pwdata[POS_W-1:0];
        REG_CENTER_Z:    center_z_r    <= cfg_pwdata[POS_W-1:0];
        REG_RADIUS_SQ:   radius_sq_r   <= cfg_pwdata[RAD_W-1:0];
        REG_HALF_HEIGHT: half_height_r <= cfg_pwdata[HH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_CENTER_X:    cfg_prdata = CFG_DATA_W'({{(CFG_DATA_W-POS_W){center_x_r[POS_W-1]}},
                                                 center_x_r});
      REG_CENTER_Y:    cfg_prdata = CFG_DATA_W'({{(CFG_DATA_W-POS_W){center_y_r[POS_W-1]}},
                                                 center_y_r});
      REG_CENTER_Z:    cfg_prdata = CFG_DATA_W'({{(CFG_DATA_W-POS_W){center_z_r[POS_W-1]}},
                                                 center_z_r});
      REG_RADIUS_SQ:   cfg_prdata = CFG_DATA_W'(radius_sq_r);
      REG_HALF_HEIGHT: cfg_prdata = CFG_DATA_W'(half_height_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: each stage moves when the stage after it is empty or
  // moving, so bubbles close up while a result waits at the output.
  // ---------------------------------------------------------------------
  assign adv3      = !out_v_r || out_tready;
  assign adv2      = !s2_v_r || adv3;
  assign in_tready = !s1_v_r || adv2;
  assign in_acc    = in_tvalid && in_tready;

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_id_r <= in_tdata[ID_W-1:0];
      s1_px_r <= in_tdata[ID_W+POS_W-1:ID_W];
      s1_py_r <= in_tdata[ID_W+2*POS_W-1:ID_W+POS_W];
      s1_pz_r <= in_tdata[ID_W+3*POS_W-1:ID_W+2*POS_W];
    end
  end

  // Stage 2: differences, squares and the slab test.
  assign dx   = DIFF_W'(s1_px_r) - DIFF_W'(center_x_r);
  assign dy   = DIFF_W'(s1_py_r) - DIFF_W'(center_y_r);
  assign dz   = DIFF_W'(s1_pz_r) - DIFF_W'(center_z_r);
  assign px2  = dx * dx;
  assign py2  = dy * dy;
  assign pz2  = dz * dz;
  // center_z - h < pos_z < center_z + h is the same as -h < dz < h.
  assign dz_w = (DIFF_W+1)'(dz);
  assign hh_w = $signed({3'b000, half_height_r});
  assign zin  = (dz_w > -hh_w) && (dz_w < hh_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_id_r  <= s1_id_r;
      s2_sqx_r <= px2[SQ_W-1:0];
      s2_sqy_r <= py2[SQ_W-1:0];
      s2_sqz_r <= pz2[SQ_W-1:0];
      s2_zin_r <= zin;
    end
  end

  // Stage 3: radius compare and membership table.
  assign dist_sq   = SUM_W'(s2_sqx_r) + SUM_W'(s2_sqy_r) + SUM_W'(s2_sqz_r);
  assign in_region = (RAD_W'(dist_sq) < radius_sq_r) && s2_zin_r;
  assign commit    = s2_v_r && adv3;

  assign tbl_req.commit    = commit;
  assign tbl_req.in_region = in_region;
  assign tbl_req.unit_id   = s2_id_r;

  srel_member_table #(
    .MEMBER_SLOTS(MEMBER_SLOTS)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (tbl_req),
    .rsp  (tbl_rsp)
  );

  assign has_result = tbl_rsp.hit ^ in_region;
  assign res_kind   = tbl_rsp.hit ? EVENT_LEAVE : EVENT_ENTER;
  assign res_ovf    = !tbl_rsp.hit && tbl_rsp.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv3) begin
      out_v_r <= commit && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && has_result) begin
      out_kind_r <= res_kind;
      out_ovf_r  <= res_ovf;
      out_unit_r <= s2_id_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_unit_r;
  assign out_tuser  = {out_ovf_r, out_kind_r};

endmodule

// File: rtl/core/srel_member_table.sv
module srel_member_table
  import srel_pkg::*;
#(
  parameter int MEMBER_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  srel_tbl_req_t req,
  output srel_tbl_rsp_t rsp
);

  logic [MEMBER_SLOTS-1:0] valid_r;
  logic [MEMBER_SLOTS-1:0] valid_nxt;
  logic [ID_W-1:0]         id_r [MEMBER_SLOTS];
  logic [MEMBER_SLOTS-1:0] hit_vec;
  logic [MEMBER_SLOTS-1:0] free_vec;
  logic                    hit;
  logic                    full;
  logic                    do_remove;
  logic                    do_insert;

  // A unit is recorded only when it is not already present, so at most one
  // slot can match.
  always_comb begin
    for (int i = 0; i < MEMBER_SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (id_r[i] == req.unit_id);
    end
  end

  // Lowest clear bit of the valid vector, as a one-hot.
  assign free_vec  = ~valid_r & (valid_r + MEMBER_SLOTS'(1));
  assign hit       = |hit_vec;
  assign full      = &valid_r;
  assign do_remove = req.commit && hit && !req.in_region;
  assign do_insert = req.commit && !hit && req.in_region && !full;

  always_comb begin
    valid_nxt = valid_r;
    if (do_remove) begin
      valid_nxt = valid_r & ~hit_vec;
    end else if (do_insert) begin
      valid_nxt = valid_r | free_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MEMBER_SLOTS; i++) begin
      if (do_insert && free_vec[i]) begin
        id_r[i] <= req.unit_id;
      end
    end
  end

  assign rsp.hit  = hit;
  assign rsp.full = full;

endmodule

// File: rtl/core/srel_checker.sv
module srel_checker
  import srel_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [ID_W-1:0]       out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  cfg_pready
);

`include "sphere_region_enter_leave_top_assert.svh"

  // A waiting result word keeps its contents until it is taken.
  `SREL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Only an enter can report a full table.
  `SREL_ASSERT_SAME(a_leave_no_ovf, clk, rst_n, out_tvalid && (out_tuser[0] == EVENT_LEAVE), !out_tuser[1])

  // Reset drains the result register.
  `SREL_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid)

  // The configuration port never inserts wait states.
  `SREL_ASSERT_SAME(a_cfg_ready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind sphere_region_enter_leave_top srel_checker u_srel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_pready(cfg_pready)
);
